[hw/rtl/frame_rate_credit_limiter_defines.svh]
// Assertion macros shared by the frame rate credit limiter checkers.
// Depends on nothing; expects clk and rst_n to be visible where used.
`ifndef FRAME_RATE_CREDIT_LIMITER_DEFINES_SVH
`define FRAME_RATE_CREDIT_LIMITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame rate credit limiter check failed");

// The consequent must hold in the cycle after the antecedent.
`define FRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame rate credit limiter check failed");

`endif

[hw/rtl/frl_pkg.sv]
// Package for the frame rate credit limiter: codes, widths and constants.
// Used by every RTL module and by the checker; depends on nothing.
package frl_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_QUERY = 2'd1,
        OP_SEND  = 2'd2
    } frl_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_FIFO_ERR = 2'd2
    } frl_status_t;

    // Mode decoded from the load level, plus the credit clear of a level write.
    typedef struct packed {
        logic paused;
        logic bypass;
        logic clear_credit;
    } frl_mode_t;

    localparam int MAX_FRAMES_PER_SECOND_DEF = 4300;
    localparam int FIFO_DEPTH_DEF            = 32;

    localparam int LEVEL_W    = 7;
    localparam int SLOTS_W    = 6;
    localparam int CREDIT_W   = 15;
    localparam int FRAMES_W   = 6;

    localparam logic [LEVEL_W-1:0]  LEVEL_FULL       = 7'd100;
    localparam logic [CREDIT_W-1:0] CREDIT_PER_FRAME = 15'd1000;
    localparam logic [CREDIT_W-1:0] CREDIT_CAP       = 15'd32000;
    localparam int                  ROUND_HALF       = 50;

    // credit / 1000 as (credit * 33555) >> 25. The reciprocal is 568/(1000*2^25) too
    // large per unit, which stays below one step for every 15-bit credit.
    localparam int                  CF_SHIFT = 25;
    localparam logic [15:0]         CF_RECIP = 16'd33555;

endpackage

[hw/rtl/frl_cfg.sv]
// Load level register and per-tick refill amount for the credit limiter.
// Depends on frl_pkg.
module frl_cfg
    import frl_pkg::*;
#(
    parameter int MAX_FRAMES_PER_SECOND = MAX_FRAMES_PER_SECOND_DEF,
    parameter int RW = $clog2(MAX_FRAMES_PER_SECOND + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [LEVEL_W-1:0] wr_level,
    output frl_mode_t          mode,
    output logic [RW-1:0]      refill
);

    // Rounded product MAX*level + 50, then a divide by 100 by reciprocal.
    localparam int PW = $clog2(MAX_FRAMES_PER_SECOND * 100 + ROUND_HALF + 1);
    localparam int K  = PW + 7;
    localparam logic [63:0] RECIP64 = ((64'd1 << K) + 64'd99) / 64'd100;
    localparam int MW = $clog2(RECIP64 + 64'd1);
    localparam logic [MW-1:0] RECIP = MW'(RECIP64);
    localparam logic [PW-1:0] PROD_RESET =
        PW'(MAX_FRAMES_PER_SECOND * 100 + ROUND_HALF);

    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic [PW-1:0]      prod_reg;
    logic [PW-1:0]      prod_next;
    logic [RW-1:0]      refill_reg;
    logic [RW-1:0]      refill_next;
    logic               level_ok;
    logic [PW+MW-1:0]   quot_full;

    // Values above 100 are dropped and leave the credit alone.
    assign level_ok   = wr_en && (wr_level <= LEVEL_FULL);
    assign level_next = level_ok ? wr_level : level_reg;
    assign prod_next  = level_ok
                      ? PW'(MAX_FRAMES_PER_SECOND) * PW'(wr_level) + PW'(ROUND_HALF)
                      : prod_reg;

    assign quot_full   = (PW+MW)'(prod_reg) * (PW+MW)'(RECIP);
    assign refill_next = RW'(quot_full >> K);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= LEVEL_FULL;
            prod_reg   <= PROD_RESET;
            refill_reg <= '0;
        end
        else
        begin
            level_reg  <= level_next;
            prod_reg   <= prod_next;
            refill_reg <= refill_next;
        end
    end

    assign mode.paused       = (level_reg == '0);
    assign mode.bypass       = (level_reg == LEVEL_FULL);
    assign mode.clear_credit = level_ok;
    assign refill            = refill_reg;

endmodule

[hw/rtl/frl_pipe.sv]
// Input register, credit update and result register of the credit limiter.
// Depends on frl_pkg.
module frl_pipe
    import frl_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    parameter int RW = 13
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  frl_mode_t           mode,
    input  logic [RW-1:0]       refill,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [SLOTS_W-1:0]  fifo_free_slots,
    input  logic                fifo_accepts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [FRAMES_W-1:0] frame_quota,
    output logic [1:0]          send_status,
    output logic                idle
);

    localparam int SW = ((RW > CREDIT_W) ? RW : CREDIT_W) + 1;
    localparam int CW = CREDIT_W + 16;

    logic                in_vld_reg;
    logic                in_vld_next;
    frl_op_t             op_reg;
    logic [SLOTS_W-1:0]  free_reg;
    logic                acc_reg;
    logic                out_vld_reg;
    logic                out_vld_next;
    logic [FRAMES_W-1:0] allowed_reg;
    logic [FRAMES_W-1:0] allowed_next;
    frl_status_t         status_reg;
    frl_status_t         status_next;
    logic [CREDIT_W-1:0] credit_reg;
    logic [CREDIT_W-1:0] credit_next;

    logic                advance;
    logic                fire;
    logic                take;
    logic                throttled;
    logic [SLOTS_W-1:0]  free_sat;
    logic [SW-1:0]       sum;
    logic [CW-1:0]       cf_prod;
    logic [FRAMES_W-1:0] credit_frames;
    logic [CREDIT_W-1:0] step_credit;

    function automatic frl_status_t fifo_status(input logic accepts);
        return accepts ? ST_OK : ST_FIFO_ERR;
    endfunction

    assign advance   = !out_vld_reg || out_ready;
    assign in_ready  = !in_vld_reg || advance;
    assign take      = in_valid && in_ready;
    assign fire      = in_vld_reg && advance;
    assign idle      = !in_vld_reg && !out_vld_reg;
    assign throttled = !mode.paused && !mode.bypass;

    assign free_sat = ({1'b0, free_reg} > 7'(FIFO_DEPTH)) ? SLOTS_W'(FIFO_DEPTH) : free_reg;
    assign sum      = SW'(credit_reg) + SW'(refill);
    assign cf_prod  = CW'(credit_reg) * CW'(CF_RECIP);
    assign credit_frames = FRAMES_W'(cf_prod >> CF_SHIFT);

    always_comb
    begin
        step_credit  = credit_reg;
        allowed_next = '0;
        status_next  = ST_OK;
        case (op_reg)
            OP_TICK:
            begin
                if (!throttled)
                    step_credit = '0;
                else if (sum > SW'(CREDIT_CAP))
                    step_credit = CREDIT_CAP;
                else
                    step_credit = CREDIT_W'(sum);
            end
            OP_QUERY:
            begin
                if (mode.bypass)
                    allowed_next = free_sat;
                else if (!mode.paused)
                    allowed_next = (credit_frames > free_sat) ? free_sat : credit_frames;
            end
            OP_SEND:
            begin
                if (mode.paused)
                    status_next = ST_BUSY;
                else if (mode.bypass)
                    status_next = fifo_status(acc_reg);
                else if (credit_reg < CREDIT_PER_FRAME)
                    status_next = ST_BUSY;
                else
                begin
                    status_next = fifo_status(acc_reg);
                    if (acc_reg)
                        step_credit = credit_reg - CREDIT_PER_FRAME;
                end
            end
            default:
            begin
                step_credit = credit_reg;
            end
        endcase
    end

    // A level write only comes with the pipeline empty, so the clear wins.
    assign credit_next  = mode.clear_credit ? '0 : (fire ? step_credit : credit_reg);
    assign in_vld_next  = in_ready ? in_valid : in_vld_reg;
    assign out_vld_next = advance ? in_vld_reg : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            credit_reg  <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            credit_reg  <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg   <= frl_op_t'(opcode);
            free_reg <= fifo_free_slots;
            acc_reg  <= fifo_accepts;
        end
        if (fire)
        begin
            allowed_reg <= allowed_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign frame_quota = allowed_reg;
    assign send_status = status_reg;

endmodule

[hw/rtl/frame_rate_credit_limiter.sv]
// A beat passes the input register and then the result register that drives out_valid.
// Throughput: one beat per cycle while out_ready is high; the credit updates once per
// beat. A level write is taken only with the pipeline empty and no input beat offered;
// its refill passes the product register and then the refill register before the first
// following beat reaches the credit logic.
// Reset (asynchronous, active low): level 100, credit 0, both pipeline stages empty.
module frame_rate_credit_limiter
    import frl_pkg::*;
#(
    parameter int MAX_FRAMES_PER_SECOND = MAX_FRAMES_PER_SECOND_DEF,
    parameter int FIFO_DEPTH            = FIFO_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LEVEL_W-1:0]  load_level_percent,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [SLOTS_W-1:0]  fifo_free_slots,
    input  logic                fifo_accepts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [FRAMES_W-1:0] frame_quota,
    output logic [1:0]          send_status
);

    localparam int RW = $clog2(MAX_FRAMES_PER_SECOND + 1);

    frl_mode_t     mode;
    logic [RW-1:0] refill;
    logic          idle;

    // An offered input beat holds the write off, so the beat never sees a stale refill.
    assign cfg_ready = idle && !in_valid;

    frl_cfg #(
        .MAX_FRAMES_PER_SECOND (MAX_FRAMES_PER_SECOND),
        .RW                    (RW)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_level (load_level_percent),
        .mode     (mode),
        .refill   (refill)
    );

    frl_pipe #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .RW         (RW)
    ) u_pipe (
        .clk             (clk),
        .rst_n           (rst_n),
        .mode            (mode),
        .refill          (refill),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .fifo_free_slots (fifo_free_slots),
        .fifo_accepts    (fifo_accepts),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_quota     (frame_quota),
        .send_status     (send_status),
        .idle            (idle)
    );

endmodule

[hw/rtl/frl_checker.sv]
// Port-level checker for the frame rate credit limiter, bound to the top level.
// Depends on frl_pkg and frame_rate_credit_limiter_defines.svh.
`include "frame_rate_credit_limiter_defines.svh"

module frl_checker
    import frl_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_ready,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [FRAMES_W-1:0] frame_quota,
    input logic [1:0]          send_status
);

    // A stalled result beat must not be withdrawn.
    `FRL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // Only a query carries a frame count, and a send status is never set on it.
    `FRL_ASSERT_SAME(a_status_excl, out_valid && send_status != ST_OK, frame_quota == '0)

    `FRL_ASSERT_SAME(a_allowed_max, out_valid, 7'(frame_quota) <= 7'(FIFO_DEPTH))

    // An accepted beat means the pipeline is busy on the next cycle.
    `FRL_ASSERT_NEXT(a_cfg_blocked, in_valid && in_ready, !cfg_ready)

endmodule

bind frame_rate_credit_limiter frl_checker #(
    .FIFO_DEPTH (FIFO_DEPTH)
) u_frl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ready   (cfg_ready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_quota (frame_quota),
    .send_status (send_status)
);

[tb/frl_result_checker.sv]
// Result checker for the frame rate credit limiter: follows the level writes
// and input beats, predicts every result and compares it when it leaves.
// Depends on frl_pkg for widths, codes and constants.
module frl_result_checker
    import frl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [LEVEL_W-1:0]  load_level_percent,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [SLOTS_W-1:0]  fifo_free_slots,
    input  logic                fifo_accepts,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [FRAMES_W-1:0] frame_quota,
    input  logic [1:0]          send_status,
    output int                  results_waiting,
    output int                  mismatch_count
);

    typedef struct packed {
        logic [FRAMES_W-1:0] frames;
        frl_status_t         status;
    } limiter_result_t;

    logic [LEVEL_W-1:0]  level_model  = LEVEL_FULL;
    logic [CREDIT_W-1:0] credit_model = '0;
    limiter_result_t     pending_results[$];
    limiter_result_t     oldest;

    // Works out the result of one beat and moves the credit bucket along.
    function automatic limiter_result_t bucket_step(input logic [1:0]         op_bits,
                                                    input logic [SLOTS_W-1:0] slots_raw,
                                                    input logic               accepts);
        limiter_result_t res;
        int  slots;
        int  refill;
        int  sum;
        int  frames;
        bit  paused;
        bit  unthrottled;
        res.frames  = '0;
        res.status  = ST_OK;
        slots       = (int'(slots_raw) > FIFO_DEPTH_DEF) ? FIFO_DEPTH_DEF : int'(slots_raw);
        paused      = (level_model == '0);
        unthrottled = (level_model >= LEVEL_FULL);
        refill      = (MAX_FRAMES_PER_SECOND_DEF * int'(level_model) + ROUND_HALF)
                      / int'(LEVEL_FULL);
        case (op_bits)
            OP_TICK: begin
                if (paused || unthrottled)
                    credit_model = '0;
                else
                begin
                    sum = int'(credit_model) + refill;
                    credit_model = (sum > int'(CREDIT_CAP)) ? CREDIT_CAP : CREDIT_W'(sum);
                end
            end
            OP_QUERY: begin
                if (unthrottled)
                    res.frames = FRAMES_W'(slots);
                else if (!paused)
                begin
                    frames = int'(credit_model) / int'(CREDIT_PER_FRAME);
                    if (frames > slots)
                        frames = slots;
                    res.frames = FRAMES_W'(frames);
                end
            end
            OP_SEND: begin
                if (paused)
                    res.status = ST_BUSY;
                else if (unthrottled)
                    res.status = accepts ? ST_OK : ST_FIFO_ERR;
                else if (credit_model < CREDIT_PER_FRAME)
                    res.status = ST_BUSY;
                else if (accepts)
                begin
                    credit_model = credit_model - CREDIT_PER_FRAME;
                    res.status   = ST_OK;
                end
                else
                    res.status = ST_FIFO_ERR;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_model  = LEVEL_FULL;
            credit_model = '0;
            pending_results.delete();
            results_waiting = 0;
            mismatch_count  = 0;
        end
        else
        begin
            // Levels above full scale are dropped and leave the credit alone.
            if (cfg_valid && cfg_ready && load_level_percent <= LEVEL_FULL)
            begin
                level_model  = load_level_percent;
                credit_model = '0;
            end
            if (in_valid && in_ready)
                pending_results.push_back(bucket_step(opcode, fifo_free_slots, fifo_accepts));
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing predicted: frame_quota %0d, send_status %0d",
                           frame_quota, send_status);
                    mismatch_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (frame_quota !== oldest.frames)
                    begin
                        $error("frame_quota: expected %0d, actual %0d",
                               oldest.frames, frame_quota);
                        mismatch_count++;
                    end
                    if (send_status !== oldest.status)
                    begin
                        $error("send_status: expected %0d, actual %0d",
                               oldest.status, send_status);
                        mismatch_count++;
                    end
                end
            end
            results_waiting = pending_results.size();
        end
    end

endmodule

[tb/tb_frame_rate_credit_limiter.sv]
// Top of the frame rate credit limiter bench: clock, reset, stimulus, level
// writes, receiver stalls, watchdog and verdict. Depends on frl_pkg, the
// block itself and frl_result_checker.
module tb_frame_rate_credit_limiter;
    import frl_pkg::*;

    localparam int          IDLE_LIMIT    = 3000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_PHASES = 14;
    localparam int          PHASE_BEATS   = 125;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;

    logic                clk             = 1'b0;
    logic                rst_n           = 1'b0;
    logic                cfg_valid       = 1'b0;
    logic                cfg_ready;
    logic [LEVEL_W-1:0]  level_wdata     = '0;
    logic                in_valid        = 1'b0;
    logic                in_ready;
    logic [1:0]          opcode          = '0;
    logic [SLOTS_W-1:0]  fifo_free_slots = '0;
    logic                fifo_accepts    = 1'b0;
    logic                out_valid;
    logic                out_ready       = 1'b0;
    logic [FRAMES_W-1:0] frame_quota;
    logic [1:0]          send_status;

    int results_waiting;
    int mismatch_count;
    int idle_cycles   = 0;
    bit hold_request  = 1'b0;
    bit sender_steady = 1'b0;

    always #10 clk = ~clk;

    frame_rate_credit_limiter i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .load_level_percent (level_wdata),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .opcode             (opcode),
        .fifo_free_slots    (fifo_free_slots),
        .fifo_accepts       (fifo_accepts),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .frame_quota        (frame_quota),
        .send_status        (send_status)
    );

    frl_result_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .load_level_percent (level_wdata),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .opcode             (opcode),
        .fifo_free_slots    (fifo_free_slots),
        .fifo_accepts       (fifo_accepts),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .frame_quota        (frame_quota),
        .send_status        (send_status),
        .results_waiting    (results_waiting),
        .mismatch_count     (mismatch_count)
    );

    // Mostly short pauses, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEVEL_FULL;
            2:       return LEVEL_W'($urandom_range(101, 127));
            default: return LEVEL_W'($urandom_range(1, 99));
        endcase
    endfunction

    task automatic send_beat(input logic [1:0]         op,
                             input logic [SLOTS_W-1:0] slots,
                             input logic               accepts);
        int gap;
        @(negedge clk);
        in_valid        = 1'b1;
        opcode          = op;
        fifo_free_slots = slots;
        fifo_accepts    = accepts;
        do @(posedge clk); while (!in_ready);
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic random_beat(input int tick_pct);
        int                 r;
        logic [1:0]         op;
        logic [SLOTS_W-1:0] slots;
        r = $urandom_range(0, 99);
        if (r < tick_pct)
            op = OP_TICK;
        else if (r < 96)
            op = ($urandom_range(0, 1) == 0) ? OP_QUERY : OP_SEND;
        else
            op = OP_UNUSED;
        if ($urandom_range(0, 3) == 0)
            slots = SLOTS_W'($urandom_range(0, 63));
        else
            slots = SLOTS_W'($urandom_range(0, FIFO_DEPTH_DEF));
        send_beat(op, slots, $urandom_range(0, 4) != 0);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (results_waiting != 0)
            @(negedge clk);
    endtask

    task automatic write_level(input logic [LEVEL_W-1:0] level);
        wait_drained();
        @(negedge clk);
        cfg_valid   = 1'b1;
        level_wdata = level;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver: alternating ready runs and stalls, plus one long hold-off on request.
    initial
    begin : receiver
        int cycles_left;
        cycles_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready    = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                cycles_left = 0;
            end
            else if (cycles_left > 0)
                cycles_left--;
            else if (out_ready)
            begin
                cycles_left = pick_gap();
                if (cycles_left > 0)
                begin
                    out_ready   = 1'b0;
                    cycles_left = cycles_left - 1;
                end
                else
                    cycles_left = $urandom_range(1, 40);
            end
            else
            begin
                out_ready   = 1'b1;
                cycles_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT - 1)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int tick_pct;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Full scale after reset: the FIFO decides alone, free counts saturate.
        send_beat(OP_QUERY, '0, 1'b1);
        send_beat(OP_QUERY, 6'd63, 1'b0);
        send_beat(OP_SEND, 6'd10, 1'b1);
        send_beat(OP_SEND, 6'd10, 1'b0);
        send_beat(OP_UNUSED, 6'd63, 1'b1);
        send_beat(OP_TICK, 6'd5, 1'b0);

        // Paused: nothing may be sent.
        write_level('0);
        send_beat(OP_QUERY, 6'd32, 1'b1);
        send_beat(OP_SEND, 6'd32, 1'b1);
        send_beat(OP_TICK, 6'd32, 1'b1);

        // Throttled near the top: empty bucket, refill, FIFO refusal, debit, cap.
        write_level(7'd99);
        send_beat(OP_SEND, 6'd32, 1'b1);
        send_beat(OP_TICK, 6'd32, 1'b1);
        send_beat(OP_QUERY, 6'd63, 1'b1);
        send_beat(OP_SEND, 6'd32, 1'b0);
        send_beat(OP_SEND, 6'd32, 1'b1);
        repeat (8) send_beat(OP_TICK, 6'd0, 1'b0);
        send_beat(OP_QUERY, 6'd40, 1'b1);
        send_beat(OP_QUERY, 6'd5, 1'b1);

        // Out-of-range levels must not touch level or credit.
        write_level(7'd127);
        write_level(7'd101);
        send_beat(OP_QUERY, 6'd31, 1'b1);

        write_level(7'd1);
        send_beat(OP_TICK, 6'd32, 1'b1);
        send_beat(OP_SEND, 6'd32, 1'b1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_level(pick_level());
            tick_pct      = $urandom_range(15, 55);
            sender_steady = (phase == 2) || (phase % 5 == 4);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // Hold the receiver off while the sender keeps streaming.
                if (phase == 2 && n == 20)
                    hold_request = 1'b1;
                random_beat(tick_pct);
            end
        end
        sender_steady = 1'b0;

        wait_drained();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
